// File: sv/lroe_pkg.sv
// Shared constants, types and command/status bundles of the line run extractor.
`default_nettype none
package lroe_pkg;

   // Longest line in pixels; a line that reaches it ends there.
   localparam int LINE_LEN   = 2048;
   localparam int AW         = $clog2(LINE_LEN);
   localparam int KW         = AW;
   localparam int LW         = $clog2(LINE_LEN + 1);
   localparam int SUM_W      = $clog2(LINE_LEN * 255 + 1);
   localparam int NUM_W      = SUM_W + 8;
   localparam int DCW        = $clog2(NUM_W);
   localparam int PSW        = LW + 2;
   localparam int THR_W      = 20;
   localparam int OUT_W      = 12;
   localparam int LUM_W      = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE           = 3'd0,
      CSR_START_LEVEL    = 3'd1,
      CSR_RUN_LEVEL      = 3'd2,
      CSR_TRIM_RATIO     = 3'd3,
      CSR_EDGE_THRESHOLD = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [OUT_W-1:0]        position_x2;
      logic [OUT_W-1:0]        thickness;
      logic signed [LUM_W-1:0] luminosity;
   } result_type;

   typedef struct packed {
      logic step;
      logic calc_thr;
      logic rd_front;
      logic adv_front;
      logic init_back;
      logic rd_back;
      logic adv_back;
      logic div_init;
      logic div_step;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic close_now;
      logic front_end;
      logic trim_hit;
      logic back_end;
      logic div_last;
      logic full;
   } sts_type;

endpackage
`default_nettype wire

// File: sv/lroe_if.sv
// Item channel interfaces: pixel request channel and run result channel.
`default_nettype none
interface lroe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic       line_end;
   modport source (output valid, output pixel, output line_end, input ready);
   modport sink (input valid, input pixel, input line_end, output ready);
endinterface

interface lroe_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [lroe_pkg::OUT_W-1:0]            position_x2;
   logic [lroe_pkg::OUT_W-1:0]            thickness;
   logic signed [lroe_pkg::LUM_W-1:0]     luminosity;
   modport source (output valid, output position_x2, output thickness,
                   output luminosity, input ready);
   modport sink (input valid, input position_x2, input thickness,
                 input luminosity, output ready);
endinterface
`default_nettype wire

// File: sv/line_run_observation_extractor.sv
// Top level of the line run extractor: controller plus datapath.
//
//   channel | direction | handshake          | payload
//   req_if  | in        | valid/ready        | pixel, line_end
//   rsp_if  | out       | valid/ready        | position_x2, thickness, luminosity
//   csr_*   | in        | csr_we, no wait    | csr_index, csr_wdata
//
// A pixel that closes nothing, and every pixel in gradient mode, is accepted
// without leaving the idle state. Closing a dark run stalls the pixels after the
// closing pixel: the trim walk reads the run store entries in turn through the registered
// read port, then a restoring divider yields one quotient bit a cycle for the
// 27-bit numerator, plus any wait for a free result slot.
// Reset is synchronous and needs no clearing pass. Results wait in a two-entry
// queue; pixels stall only when it is full or a run is being closed.
`default_nettype none
module line_run_observation_extractor (
   input  wire logic                                clock,
   input  wire logic                                reset,
   lroe_req_if.sink                                 req_if,
   lroe_rsp_if.source                               rsp_if,
   input  wire logic                                csr_we,
   input  wire logic [lroe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lroe_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   lroe_pkg::cmd_type    cmd;
   lroe_pkg::sts_type    sts;
   lroe_pkg::result_type rsp_data;
   logic                 rsp_valid;
   logic                 req_ready;

   lroe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lroe_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_pixel    (req_if.pixel),
      .req_line_end (req_if.line_end),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_data     (rsp_data)
   );

   assign req_if.ready       = req_ready;
   assign rsp_if.valid       = rsp_valid;
   assign rsp_if.position_x2 = rsp_data.position_x2;
   assign rsp_if.thickness   = rsp_data.thickness;
   assign rsp_if.luminosity  = rsp_data.luminosity;

endmodule
`default_nettype wire

// File: sv/lroe_ctrl.sv
// Controller: accepts pixels and sequences the trim walk and mean division.
`default_nettype none
module lroe_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lroe_pkg::sts_type sts,
   output lroe_pkg::cmd_type      cmd
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_THR   = 9'b000000010,
      S_FRD   = 9'b000000100,
      S_FCMP  = 9'b000001000,
      S_BRD   = 9'b000010000,
      S_BCMP  = 9'b000100000,
      S_DINIT = 9'b001000000,
      S_DIV   = 9'b010000000,
      S_PUSH  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Take a pixel only when idle and a result slot is free
   assign req_ready = (state_ff == S_IDLE) && !sts.full;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.step = 1'b1;
               if (sts.close_now) state_in = S_THR;
            end
         end
         S_THR: begin
            cmd.calc_thr = 1'b1;
            state_in     = S_FRD;
         end
         S_FRD: begin
            if (sts.front_end) begin
               state_in = S_IDLE;
            end else begin
               cmd.rd_front = 1'b1;
               state_in     = S_FCMP;
            end
         end
         S_FCMP: begin
            if (sts.trim_hit) begin
               cmd.adv_front = 1'b1;
               state_in      = S_FRD;
            end else begin
               cmd.init_back = 1'b1;
               state_in      = S_BRD;
            end
         end
         S_BRD: begin
            if (sts.back_end) begin
               state_in = S_DINIT;
            end else begin
               cmd.rd_back = 1'b1;
               state_in    = S_BCMP;
            end
         end
         S_BCMP: begin
            if (sts.trim_hit) begin
               cmd.adv_back = 1'b1;
               state_in     = S_BRD;
            end else begin
               state_in = S_DINIT;
            end
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_PUSH;
         end
         S_PUSH: begin
            if (!sts.full) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

// File: sv/lroe_dp.sv
// Datapath: settings, run and edge tracking, run store, trim walk, divider, result queue.
`default_nettype none
module lroe_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [7:0]                          req_pixel,
   input  wire logic                                req_line_end,
   input  wire logic                                csr_we,
   input  wire logic [lroe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lroe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire lroe_pkg::cmd_type                   cmd,
   output lroe_pkg::sts_type                        sts,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output lroe_pkg::result_type                     rsp_data
);

   localparam int KW    = lroe_pkg::KW;
   localparam int LW    = lroe_pkg::LW;
   localparam int AW    = lroe_pkg::AW;
   localparam int SUM_W = lroe_pkg::SUM_W;
   localparam int NUM_W = lroe_pkg::NUM_W;
   localparam int DCW   = lroe_pkg::DCW;
   localparam int PSW   = lroe_pkg::PSW;
   localparam int THR_W = lroe_pkg::THR_W;
   localparam int OUT_W = lroe_pkg::OUT_W;
   localparam int LUM_W = lroe_pkg::LUM_W;

   // Settings
   logic       mode_ff, mode_in;
   logic [7:0] start_level_ff, start_level_in;
   logic [7:0] run_level_ff, run_level_in;
   logic [8:0] trim_ratio_ff, trim_ratio_in;
   logic [7:0] edge_threshold_ff, edge_threshold_in;

   // Line and run tracking
   logic [KW-1:0]    pix_idx_ff, pix_idx_in;
   logic [KW-1:0]    run_start_ff, run_start_in;
   logic [LW-1:0]    run_len_ff, run_len_in;
   logic [7:0]       run_min_ff, run_min_in;
   logic [SUM_W-1:0] run_sum_ff, run_sum_in;
   logic             run_active_ff, run_active_in;
   logic [7:0]       prev0_ff, prev0_in;
   logic [7:0]       prev1_ff, prev1_in;
   logic             edge_sign_ff, edge_sign_in;
   logic [7:0]       edge_base_ff, edge_base_in;

   // Walk and divider
   logic signed [THR_W-1:0] thr_ff, thr_in;
   logic [LW-1:0]           wi_ff, wi_in;
   logic [LW-1:0]           wj_ff, wj_in;
   logic [SUM_W-1:0]        wsum_ff, wsum_in;
   logic [7:0]              rd_data_ff;
   logic [LW-1:0]           rem_ff, rem_in;
   logic [NUM_W-1:0]        quo_ff, quo_in;
   logic [DCW-1:0]          dcnt_ff, dcnt_in;
   logic [LW-1:0]           th_ff, th_in;
   logic [OUT_W-1:0]        pos_ff, pos_in;

   // Result queue
   lroe_pkg::result_type q_ff [2];
   logic                 q_head_ff, q_head_in;
   logic [1:0]           q_cnt_ff, q_cnt_in;

   // Run store
   logic [7:0]    store_mem [lroe_pkg::LINE_LEN];
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   logic                 last;
   logic [KW-1:0]        m_idx;
   logic signed [9:0]    grad;
   logic signed [9:0]    grad_neg;
   logic signed [9:0]    grad_abs;
   logic signed [9:0]    ethr;
   logic                 grad_cont;
   logic                 grad_push;
   lroe_pkg::result_type grad_res;
   lroe_pkg::result_type push_res;
   logic                 push;
   logic                 pop;
   logic                 q_tail;
   logic signed [9:0]    lvl_diff;
   logic signed [THR_W-1:0] trim_prod;
   logic signed [THR_W-1:0] data_s;
   logic [LW-1:0]        th_calc;
   logic [PSW-1:0]       pos_calc;
   logic [LW:0]          rem_sh;
   logic                 rem_ge;
   logic [7:0]           app_min;

   // Write settings
   always_comb begin
      mode_in           = mode_ff;
      start_level_in    = start_level_ff;
      run_level_in      = run_level_ff;
      trim_ratio_in     = trim_ratio_ff;
      edge_threshold_in = edge_threshold_ff;
      if (csr_we) begin
         case (csr_index)
            lroe_pkg::CSR_MODE:           mode_in           = csr_wdata[0];
            lroe_pkg::CSR_START_LEVEL:    start_level_in    = csr_wdata[7:0];
            lroe_pkg::CSR_RUN_LEVEL:      run_level_in      = csr_wdata[7:0];
            lroe_pkg::CSR_TRIM_RATIO:     trim_ratio_in     = csr_wdata;
            lroe_pkg::CSR_EDGE_THRESHOLD: edge_threshold_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Per-pixel step
   assign last     = req_line_end || (pix_idx_ff == KW'(lroe_pkg::LINE_LEN - 1));
   assign m_idx    = pix_idx_ff - KW'(1);
   assign grad     = $signed({2'b00, req_pixel}) - $signed({2'b00, prev1_ff});
   assign grad_neg = -grad;
   assign grad_abs = grad[9] ? grad_neg : grad;
   assign ethr     = $signed({2'b00, edge_threshold_ff});
   assign grad_cont = edge_sign_ff ? (grad_neg >= ethr) : (grad >= ethr);
   assign app_min  = (req_pixel < run_min_ff) ? req_pixel : run_min_ff;

   // Flag a dark run that this pixel would close
   assign sts.close_now = !mode_ff &&
                          (run_active_ff ? (req_pixel > run_level_ff || last)
                                         : (req_pixel < start_level_ff &&
                                            req_pixel <= run_level_ff && last));

   always_comb begin
      pix_idx_in    = pix_idx_ff;
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      run_min_in    = run_min_ff;
      run_sum_in    = run_sum_ff;
      run_active_in = run_active_ff;
      prev0_in      = prev0_ff;
      prev1_in      = prev1_ff;
      edge_sign_in  = edge_sign_ff;
      edge_base_in  = edge_base_ff;
      wr_en         = 1'b0;
      wr_addr       = run_len_ff[AW-1:0];
      grad_push     = 1'b0;
      grad_res      = '0;
      if (cmd.step) begin
         if (!mode_ff) begin
            // Dark run: extend, close or open
            if (run_active_ff) begin
               if (req_pixel <= run_level_ff) begin
                  if (run_len_ff < LW'(lroe_pkg::LINE_LEN)) begin
                     wr_en      = 1'b1;
                     run_len_in = run_len_ff + LW'(1);
                     run_sum_in = run_sum_ff + SUM_W'(req_pixel);
                     run_min_in = app_min;
                  end
                  run_active_in = 1'b1;
               end else begin
                  run_active_in = 1'b0;
               end
            end else if (req_pixel < start_level_ff && req_pixel <= run_level_ff) begin
               wr_en         = 1'b1;
               wr_addr       = '0;
               run_start_in  = pix_idx_ff;
               run_len_in    = LW'(1);
               run_sum_in    = SUM_W'(req_pixel);
               run_min_in    = req_pixel;
               run_active_in = 1'b1;
            end
         end else if (pix_idx_ff >= KW'(2)) begin
            // Gradient edge: judge the centre one pixel back
            if (run_active_ff) begin
               if (!grad_cont) begin
                  run_active_in        = 1'b0;
                  grad_push            = 1'b1;
                  grad_res.position_x2 = OUT_W'({1'b0, run_start_ff} + {1'b0, m_idx}
                                                - (KW + 1)'(1));
                  grad_res.thickness   = OUT_W'(m_idx - run_start_ff);
                  grad_res.luminosity  = {$signed({1'b0, prev0_ff}) -
                                          $signed({1'b0, edge_base_ff}), 8'h00};
               end
            end else if (grad_abs > ethr) begin
               run_active_in = 1'b1;
               edge_sign_in  = grad[9];
               run_start_in  = m_idx;
               edge_base_in  = prev1_ff;
            end
            if (!grad_push && last && run_active_in) begin
               grad_push            = 1'b1;
               grad_res.position_x2 = OUT_W'({1'b0, run_start_in} + {1'b0, pix_idx_ff}
                                             - (KW + 1)'(1));
               grad_res.thickness   = OUT_W'(pix_idx_ff - run_start_in);
               grad_res.luminosity  = {$signed({1'b0, req_pixel}) -
                                       $signed({1'b0, edge_base_in}), 8'h00};
            end
         end
         prev1_in   = prev0_ff;
         prev0_in   = req_pixel;
         pix_idx_in = last ? '0 : pix_idx_ff + KW'(1);
         if (last) run_active_in = 1'b0;
      end
      // Mode change drops any open run or edge
      if (csr_we && csr_index == lroe_pkg::CSR_MODE) run_active_in = 1'b0;
   end

   // Trim threshold and walk
   assign lvl_diff  = $signed({2'b00, run_level_ff}) - $signed({2'b00, run_min_ff});
   assign trim_prod = lvl_diff * $signed({1'b0, trim_ratio_ff});
   assign data_s    = $signed({4'b0000, rd_data_ff, 8'h00});
   assign rd_addr   = cmd.rd_back ? wj_ff[AW-1:0] : wi_ff[AW-1:0];
   assign th_calc   = wj_ff - wi_ff + LW'(1);
   assign pos_calc  = PSW'({run_start_ff, 1'b0}) + PSW'(wi_ff) + PSW'(wj_ff);
   assign rem_sh    = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_ge    = rem_sh >= {1'b0, th_ff};

   always_comb begin
      thr_in  = thr_ff;
      wi_in   = wi_ff;
      wj_in   = wj_ff;
      wsum_in = wsum_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dcnt_in = dcnt_ff;
      th_in   = th_ff;
      pos_in  = pos_ff;
      if (cmd.calc_thr) begin
         thr_in  = $signed({4'b0000, run_min_ff, 8'h00}) + trim_prod;
         wi_in   = '0;
         wsum_in = run_sum_ff;
      end
      if (cmd.adv_front) begin
         wsum_in = wsum_ff - SUM_W'(rd_data_ff);
         wi_in   = wi_ff + LW'(1);
      end
      if (cmd.init_back) wj_in = run_len_ff - LW'(1);
      if (cmd.adv_back) begin
         wsum_in = wsum_ff - SUM_W'(rd_data_ff);
         wj_in   = wj_ff - LW'(1);
      end
      // Mean: (sum*256 + t/2) / t, one quotient bit a cycle
      if (cmd.div_init) begin
         th_in   = th_calc;
         pos_in  = OUT_W'(pos_calc);
         rem_in  = '0;
         quo_in  = NUM_W'({wsum_ff, 8'h00}) + NUM_W'(th_calc >> 1);
         dcnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in  = rem_ge ? LW'(rem_sh - {1'b0, th_ff}) : LW'(rem_sh);
         quo_in  = {quo_ff[NUM_W-2:0], rem_ge};
         dcnt_in = dcnt_ff + DCW'(1);
      end
   end

   assign sts.front_end = wi_ff >= run_len_ff;
   assign sts.trim_hit  = data_s > thr_ff;
   assign sts.back_end  = wj_ff <= wi_ff;
   assign sts.div_last  = dcnt_ff == DCW'(NUM_W - 1);
   assign sts.full      = q_cnt_ff == 2'd2;

   // Result queue, two entries
   assign push_res.position_x2 = pos_ff;
   assign push_res.thickness   = OUT_W'(th_ff);
   assign push_res.luminosity  = $signed(quo_ff[LUM_W-1:0]);
   assign push      = cmd.push || grad_push;
   assign pop       = rsp_valid && rsp_ready;
   assign q_tail    = q_head_ff ^ (q_cnt_ff == 2'd1);
   assign q_head_in = q_head_ff ^ pop;
   assign q_cnt_in  = q_cnt_ff + {1'b0, push} - {1'b0, pop};
   assign rsp_valid = q_cnt_ff != 2'd0;
   assign rsp_data  = q_ff[q_head_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[q_tail] <= cmd.push ? push_res : grad_res;
   end

   // Run store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= req_pixel;
      if (cmd.rd_front || cmd.rd_back) rd_data_ff <= store_mem[rd_addr];
   end

   // Payload registers
   always_ff @(posedge clock) begin
      thr_ff       <= thr_in;
      wi_ff        <= wi_in;
      wj_ff        <= wj_in;
      wsum_ff      <= wsum_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dcnt_ff      <= dcnt_in;
      th_ff        <= th_in;
      pos_ff       <= pos_in;
   end

   // Control and tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= 1'b0;
         start_level_ff    <= 8'd128;
         run_level_ff      <= 8'd160;
         trim_ratio_ff     <= 9'd128;
         edge_threshold_ff <= 8'd30;
         pix_idx_ff        <= '0;
         run_start_ff      <= '0;
         run_len_ff        <= '0;
         run_min_ff        <= 8'd255;
         run_sum_ff        <= '0;
         run_active_ff     <= 1'b0;
         prev0_ff          <= '0;
         prev1_ff          <= '0;
         edge_sign_ff      <= 1'b0;
         edge_base_ff      <= '0;
         q_head_ff         <= 1'b0;
         q_cnt_ff          <= '0;
      end else begin
         mode_ff           <= mode_in;
         start_level_ff    <= start_level_in;
         run_level_ff      <= run_level_in;
         trim_ratio_ff     <= trim_ratio_in;
         edge_threshold_ff <= edge_threshold_in;
         pix_idx_ff        <= pix_idx_in;
         run_start_ff      <= run_start_in;
         run_len_ff        <= run_len_in;
         run_min_ff        <= run_min_in;
         run_sum_ff        <= run_sum_in;
         run_active_ff     <= run_active_in;
         prev0_ff          <= prev0_in;
         prev1_ff          <= prev1_in;
         edge_sign_ff      <= edge_sign_in;
         edge_base_ff      <= edge_base_in;
         q_head_ff         <= q_head_in;
         q_cnt_ff          <= q_cnt_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/lroe_checker.sv
// Port checker for the line run extractor and its bind.
`default_nettype none
module lroe_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [lroe_pkg::OUT_W-1:0]        rsp_thickness,
   input wire logic signed [lroe_pkg::LUM_W-1:0] rsp_luminosity
);

   // Hold a stalled item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // No result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");

   // A reported run is never empty
   a_thick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_thickness != '0)
      else $error("empty run reported");

   // Luminosity stays within the full grey range (255 levels, scaled by 256) either way
   a_lum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_luminosity >= -17'sd65280) && (rsp_luminosity <= 17'sd65280))
      else $error("luminosity out of range");

endmodule

bind line_run_observation_extractor lroe_checker u_lroe_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_thickness  (rsp_if.thickness),
   .rsp_luminosity (rsp_if.luminosity)
);
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench of the line run extractor: pixel lines in, run reports checked.
`default_nettype none
module tb_top;

   localparam int LINE_LEN = lroe_pkg::LINE_LEN;
   localparam int OUT_W = lroe_pkg::OUT_W;
   localparam int LUM_W = lroe_pkg::LUM_W;
   localparam int CSR_IDX_W = lroe_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = lroe_pkg::CSR_DATA_W;
   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 9;
   // Worst dark-run close: a trim walk over every stored pixel plus the divider.
   localparam int SETTLE_CYCLES = 2 * (LINE_LEN + 2) + 300;
   localparam int STALL_LIMIT = 40000;
   localparam int RANDOM_ITEMS = 1950;
   localparam int PHASES = 8;

   typedef struct packed {
      logic [7:0] pixel;
      logic       line_end;
   } pixel_item_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lroe_req_if req_bus ();
   lroe_rsp_if rsp_bus ();

   line_run_observation_extractor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pixel_item_type       pixel_q[$];
   lroe_pkg::result_type run_report_q[$];

   int  send_idle_pct;
   int  recv_stall_pct;
   bit  req_taken;
   bit  failed;
   int  pixels_sent;
   int  reports_seen;
   int  quiet_cycles;

   // Predictor copy of the configuration and line state
   bit [0:0] cfg_mode;
   bit [7:0] cfg_start_level;
   bit [7:0] cfg_run_level;
   bit [8:0] cfg_trim_ratio;
   bit [7:0] cfg_edge_threshold;
   bit [7:0] dark_store [LINE_LEN];
   int       line_pos;
   int       span_start;
   int       dark_len;
   int       dark_min;
   int       dark_sum;
   bit       span_open;
   bit [7:0] last_pixel;
   bit [7:0] second_last_pixel;
   bit       edge_falling;
   bit [7:0] edge_base;

   function automatic void reset_line_model();
      cfg_mode = 1'b0;
      cfg_start_level = 8'd128;
      cfg_run_level = 8'd160;
      cfg_trim_ratio = 9'd128;
      cfg_edge_threshold = 8'd30;
      line_pos = 0;
      span_start = 0;
      dark_len = 0;
      dark_min = 255;
      dark_sum = 0;
      span_open = 1'b0;
      last_pixel = 8'd0;
      second_last_pixel = 8'd0;
      edge_falling = 1'b0;
      edge_base = 8'd0;
   endfunction

   function automatic void apply_register(lroe_pkg::csr_index_type idx, int value);
      case (idx)
         lroe_pkg::CSR_MODE: begin
            cfg_mode = value[0];
            span_open = 1'b0;
         end
         lroe_pkg::CSR_START_LEVEL: cfg_start_level = value[7:0];
         lroe_pkg::CSR_RUN_LEVEL: cfg_run_level = value[7:0];
         lroe_pkg::CSR_TRIM_RATIO: cfg_trim_ratio = value[8:0];
         lroe_pkg::CSR_EDGE_THRESHOLD: cfg_edge_threshold = value[7:0];
         default: ;
      endcase
   endfunction

   function automatic void store_dark(int p);
      if (dark_len < LINE_LEN) begin
         dark_store[dark_len] = p[7:0];
         dark_len++;
         dark_sum += p;
         if (p < dark_min) dark_min = p;
      end
   endfunction

   // Trim both ends of the buffered run and form the rounded mean
   function automatic bit close_dark_run(output lroe_pkg::result_type r);
      int thr;
      int first;
      int last;
      int unsigned sum;
      int unsigned th;
      span_open = 1'b0;
      r = '0;
      if (dark_len == 0) return 1'b0;
      thr = dark_min * 256 + (int'(cfg_run_level) - dark_min) * int'(cfg_trim_ratio);
      first = 0;
      sum = dark_sum;
      while (first < dark_len && int'(dark_store[first]) * 256 > thr) begin
         sum -= dark_store[first];
         first++;
      end
      if (first >= dark_len) return 1'b0;
      last = dark_len - 1;
      while (last > first && int'(dark_store[last]) * 256 > thr) begin
         sum -= dark_store[last];
         last--;
      end
      th = last - first + 1;
      r.position_x2 = OUT_W'(2 * span_start + first + last);
      r.thickness = OUT_W'(th);
      r.luminosity = LUM_W'((sum * 256 + th / 2) / th);
      return 1'b1;
   endfunction

   function automatic bit dark_step(int p, bit last, int k,
                                    output lroe_pkg::result_type r);
      r = '0;
      if (span_open) begin
         if (p <= cfg_run_level) begin
            store_dark(p);
            return last ? close_dark_run(r) : 1'b0;
         end
         return close_dark_run(r);
      end
      if (p < cfg_start_level && p <= cfg_run_level) begin
         span_open = 1'b1;
         span_start = k;
         dark_len = 0;
         dark_min = 255;
         dark_sum = 0;
         store_dark(p);
         if (last) return close_dark_run(r);
      end
      return 1'b0;
   endfunction

   function automatic bit edge_step(int p, bit last, int k,
                                    output lroe_pkg::result_type r);
      int g;
      int thr;
      int m;
      bit keep;
      r = '0;
      thr = cfg_edge_threshold;
      if (k < 2) return 1'b0;
      m = k - 1;
      g = p - int'(second_last_pixel);
      if (span_open) begin
         keep = edge_falling ? (-g >= thr) : (g >= thr);
         if (!keep) begin
            span_open = 1'b0;
            r.position_x2 = OUT_W'(span_start - 1 + m);
            r.thickness = OUT_W'(m - span_start);
            r.luminosity = LUM_W'((int'(last_pixel) - int'(edge_base)) * 256);
            return 1'b1;
         end
      end else if ((g < 0 ? -g : g) > thr) begin
         span_open = 1'b1;
         edge_falling = g < 0;
         span_start = m;
         edge_base = second_last_pixel;
      end
      if (last && span_open) begin
         span_open = 1'b0;
         r.position_x2 = OUT_W'(span_start - 1 + k);
         r.thickness = OUT_W'(k - span_start);
         r.luminosity = LUM_W'((p - int'(edge_base)) * 256);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advance the line model by one accepted pixel and queue any report
   function automatic void predict_pixel(pixel_item_type it);
      lroe_pkg::result_type r;
      bit hit;
      bit last;
      int k;
      k = line_pos;
      last = it.line_end || k >= LINE_LEN - 1;
      if (cfg_mode == 1'b0) hit = dark_step(it.pixel, last, k, r);
      else hit = edge_step(it.pixel, last, k, r);
      if (hit) run_report_q.insert(run_report_q.size(), r);
      second_last_pixel = last_pixel;
      last_pixel = it.pixel;
      if (last) begin
         line_pos = 0;
         span_open = 1'b0;
      end else begin
         line_pos = k + 1;
      end
   endfunction

   // Append one pixel item to the pending queue
   function automatic void enqueue_pixel(bit [7:0] pix, bit term);
      pixel_item_type it;
      it.pixel = pix;
      it.line_end = term;
      pixel_q.insert(pixel_q.size(), it);
   endfunction

   // Clock and reset
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.pixel = 8'd0;
      req_bus.line_end = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = lroe_pkg::CSR_MODE;
      csr_wdata = '0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // Driver: present pixels and the result ready at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || req_taken) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_bus.valid <= 1'b1;
               req_bus.pixel <= pixel_q[0].pixel;
               req_bus.line_end <= pixel_q[0].line_end;
               void'(pixel_q.pop_front());
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   // Monitor: predict on accepted pixels, check accepted reports, watch for a hang
   always @(posedge clock) begin
      lroe_pkg::result_type want;
      bit moved;
      moved = 1'b0;
      if (reset) begin
         req_taken <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            predict_pixel('{pixel: req_bus.pixel, line_end: req_bus.line_end});
            pixels_sent++;
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            reports_seen++;
            if (run_report_q.size() == 0) begin
               $error("unexpected report: x2 %0d thickness %0d luminosity %0d",
                      rsp_bus.position_x2, rsp_bus.thickness, rsp_bus.luminosity);
               failed = 1'b1;
            end else begin
               want = run_report_q.pop_front();
               if (rsp_bus.position_x2 !== want.position_x2) begin
                  $error("position_x2: expected %0d, got %0d",
                         want.position_x2, rsp_bus.position_x2);
                  failed = 1'b1;
               end
               if (rsp_bus.thickness !== want.thickness) begin
                  $error("thickness: expected %0d, got %0d",
                         want.thickness, rsp_bus.thickness);
                  failed = 1'b1;
               end
               if (rsp_bus.luminosity !== want.luminosity) begin
                  $error("luminosity: expected %0d, got %0d",
                         want.luminosity, rsp_bus.luminosity);
                  failed = 1'b1;
               end
            end
         end
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic write_register(lroe_pkg::csr_index_type idx, int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      apply_register(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all(int mode, int start_lvl, int run_lvl, int ratio, int edge_thr);
      write_register(lroe_pkg::CSR_MODE, mode);
      write_register(lroe_pkg::CSR_START_LEVEL, start_lvl);
      write_register(lroe_pkg::CSR_RUN_LEVEL, run_lvl);
      write_register(lroe_pkg::CSR_TRIM_RATIO, ratio);
      write_register(lroe_pkg::CSR_EDGE_THRESHOLD, edge_thr);
   endtask

   // Hold until every pixel is in and every report out, then let a silent close finish
   task automatic drain();
      while (pixel_q.size() > 0 || req_bus.valid || run_report_q.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_pixels(int vals[], bit term);
      foreach (vals[n])
         enqueue_pixel(vals[n][7:0], term && n == vals.size() - 1);
   endtask

   // Build a line of flat levels, steps and ramps around the current thresholds
   task automatic queue_line(int len, bit term);
      int lvl;
      int slope;
      int v;
      lvl = $urandom_range(255);
      slope = 0;
      for (int n = 0; n < len; n++) begin
         if ($urandom_range(99) < 12) begin
            slope = 0;
            case ($urandom_range(3))
               0: lvl = $urandom_range(cfg_start_level);
               1: lvl = $urandom_range(255, cfg_run_level);
               2: lvl = $urandom_range(255);
               default: slope = int'($urandom_range(80)) - 40;
            endcase
         end
         lvl += slope;
         if (lvl < 0) lvl = 0;
         if (lvl > 255) lvl = 255;
         v = lvl + int'($urandom_range(8)) - 4;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         enqueue_pixel(v[7:0], term && n == len - 1);
      end
   endtask

   initial begin
      int queued;
      int long_lines;
      int len;
      int pick;
      reset_line_model();
      failed = 1'b0;
      pixels_sent = 0;
      reports_seen = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: dark runs with trimming, single-pixel line, extremes
      write_all(0, 128, 160, 128, 30);
      push_pixels('{200, 10, 150, 0, 150, 200, 5}, 1'b1);
      push_pixels('{0}, 1'b1);
      push_pixels('{255, 127, 128, 160, 161}, 1'b1);
      drain();
      // Pixels below the start level but above the run level open nothing
      write_all(0, 255, 100, 256, 30);
      push_pixels('{150, 254, 100, 255}, 1'b1);
      drain();
      // Run left open, run level lowered: every pixel trimmed, no report
      write_all(0, 128, 160, 256, 30);
      push_pixels('{255, 100, 150, 150}, 1'b0);
      drain();
      write_register(lroe_pkg::CSR_RUN_LEVEL, 90);
      push_pixels('{200}, 1'b1);
      drain();
      // Gradient: rising edge, falling edge to line end, short line
      write_all(1, 128, 160, 128, 30);
      push_pixels('{0, 0, 100, 200, 200, 100, 0}, 1'b1);
      push_pixels('{10, 250}, 1'b1);
      drain();

      // Random phases over several settings and idle patterns
      long_lines = 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         pick = $urandom_range(3);
         write_all(ph % 2,
                   pick == 0 ? 0 : (pick == 1 ? 255 : $urandom_range(255)),
                   pick == 1 ? 0 : (pick == 2 ? 255 : $urandom_range(255)),
                   pick == 0 ? 256 : (pick == 3 ? 0 : $urandom_range(256)),
                   pick == 2 ? 0 : (pick == 3 ? 255 : $urandom_range(100)));
         queued = 0;
         while (queued < RANDOM_ITEMS / PHASES) begin
            pick = $urandom_range(99);
            if (pick < 2 && long_lines < 4) begin
               len = $urandom_range(200, 100);
               long_lines++;
            end else if (pick < 10) begin
               len = $urandom_range(2, 1);
            end else begin
               len = $urandom_range(40, 3);
            end
            queue_line(len, $urandom_range(9) != 0);
            queued += len;
         end
         drain();
      end

      $display("covered %0d pixels over %0d setting phases, %0d run reports checked",
               pixels_sent, PHASES + 5, reports_seen);
      if (!failed && run_report_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
